// File: sv/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// shared constants and types of the preemptive priority scheduler
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int MAX_TASKS  = 16;
    localparam int IDX_W      = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W      = $clog2(MAX_TASKS + 1);
    localparam int ID_W       = 4;
    localparam int TIME_W     = 24;
    localparam int ARR_W      = 16;
    localparam int BUR_W      = 16;
    localparam int PRI_W      = 8;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 64;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } pps_state_t;

    typedef struct packed {
        logic             capture;
        logic             scan_en;
        logic [IDX_W-1:0] scan_idx;
        logic             commit;
    } pps_cmd_t;

    typedef struct packed {
        logic out_busy;
    } pps_status_t;

endpackage

// File: sv/pps_ctrl.sv
// ----------------------------------------------------------------------------
// pps_ctrl
// sequencer: takes a transaction, steps the slot scan, commits the result
// ----------------------------------------------------------------------------
module pps_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tuser,
    output logic                 s_tready,
    input  pps_pkg::pps_status_t status,
    output pps_pkg::pps_cmd_t    cmd
);

    pps_pkg::pps_state_t            state_reg, state_next;
    logic [pps_pkg::IDX_W-1:0]      idx_reg, idx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pps_pkg::ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        s_tready     = 1'b0;
        cmd.capture  = 1'b0;
        cmd.scan_en  = 1'b0;
        cmd.scan_idx = idx_reg;
        cmd.commit   = 1'b0;
        unique case (state_reg)
            pps_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    idx_next    = '0;
                    state_next  = (s_tuser == pps_pkg::KIND_TICK) ? pps_pkg::ST_SCAN
                                                                  : pps_pkg::ST_COMMIT;
                end
            end
            pps_pkg::ST_SCAN: begin
                cmd.scan_en = 1'b1;
                idx_next    = idx_reg + 1'b1;
                if (idx_reg == pps_pkg::IDX_W'(pps_pkg::MAX_TASKS - 1)) begin
                    state_next = pps_pkg::ST_COMMIT;
                end
            end
            pps_pkg::ST_COMMIT: begin
                if (!status.out_busy) begin
                    cmd.commit = 1'b1;
                    state_next = pps_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pps_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/pps_datapath.sv
// ----------------------------------------------------------------------------
// pps_datapath
// task tables, running minimum over the scan, counters and result register
// ----------------------------------------------------------------------------
module pps_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tuser,
    input  logic [pps_pkg::IN_DATA_W-1:0]   s_tdata,
    input  pps_pkg::pps_cmd_t               cmd,
    output pps_pkg::pps_status_t            status,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pps_pkg::OUT_DATA_W-1:0]  m_tdata
);

    localparam int CNT_W  = pps_pkg::CNT_W;
    localparam int IDX_W  = pps_pkg::IDX_W;
    localparam int TIME_W = pps_pkg::TIME_W;
    localparam int ARR_W  = pps_pkg::ARR_W;
    localparam int BUR_W  = pps_pkg::BUR_W;
    localparam int PRI_W  = pps_pkg::PRI_W;
    localparam int ID_W   = pps_pkg::ID_W;
    localparam logic [CNT_W-1:0] NO_RUNNER = CNT_W'(pps_pkg::MAX_TASKS);

    function automatic logic [ID_W-1:0] to_id(input logic [CNT_W-1:0] s);
        logic [CNT_W+ID_W-1:0] w;
        w = {{ID_W{1'b0}}, s};
        return w[ID_W-1:0];
    endfunction

    // task tables
    logic [ARR_W-1:0] arrival_reg   [pps_pkg::MAX_TASKS];
    logic [BUR_W-1:0] burst_reg     [pps_pkg::MAX_TASKS];
    logic [BUR_W-1:0] remaining_reg [pps_pkg::MAX_TASKS];
    logic [PRI_W-1:0] priority_reg  [pps_pkg::MAX_TASKS];

    // captured transaction
    logic             kind_reg;
    logic [ARR_W-1:0] in_arr_reg;
    logic [BUR_W-1:0] in_bur_reg;
    logic [PRI_W-1:0] in_pri_reg;

    // scan result
    logic [CNT_W-1:0] best_reg;
    logic [PRI_W:0]   best_pri_reg;
    logic [ARR_W-1:0] best_arr_reg;
    logic [BUR_W-1:0] best_rem_reg;
    logic [BUR_W:0]   best_sum_reg;

    logic [CNT_W-1:0]  loaded_reg, loaded_next;
    logic [CNT_W-1:0]  finished_reg, finished_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic [CNT_W-1:0]  prev_reg, prev_next;

    logic                  m_tvalid_reg;
    logic [pps_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // scan evaluation
    logic [ARR_W-1:0] scan_arr;
    logic [BUR_W-1:0] scan_bur;
    logic [BUR_W-1:0] scan_rem;
    logic [PRI_W-1:0] scan_pri;
    logic             scan_take;

    assign scan_arr  = arrival_reg[cmd.scan_idx];
    assign scan_bur  = burst_reg[cmd.scan_idx];
    assign scan_rem  = remaining_reg[cmd.scan_idx];
    assign scan_pri  = priority_reg[cmd.scan_idx];
    assign scan_take = (CNT_W'(cmd.scan_idx) < loaded_reg)
                    && ({{(TIME_W-ARR_W){1'b0}}, scan_arr} <= time_reg)
                    && (scan_rem != '0)
                    && ({1'b0, scan_pri} < best_pri_reg);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg     <= s_tuser;
            in_arr_reg   <= s_tdata[ARR_W-1:0];
            in_bur_reg   <= s_tdata[ARR_W+BUR_W-1:ARR_W];
            in_pri_reg   <= s_tdata[ARR_W+BUR_W+PRI_W-1:ARR_W+BUR_W];
            best_reg     <= NO_RUNNER;
            best_pri_reg <= {1'b1, {PRI_W{1'b0}}};
        end else if (cmd.scan_en && scan_take) begin
            best_reg     <= CNT_W'(cmd.scan_idx);
            best_pri_reg <= {1'b0, scan_pri};
            best_arr_reg <= scan_arr;
            best_rem_reg <= scan_rem;
            best_sum_reg <= {1'b0, scan_arr} + {1'b0, scan_bur};
        end
    end

    // commit logic
    logic              load_ok;
    logic              found;
    logic              done_now;
    logic [TIME_W-1:0] time_inc;
    logic [TIME_W-1:0] turn;
    logic [TIME_W-1:0] wait_t;
    logic [TIME_W-1:0] sum_ext;
    logic              r_ran, r_sw, r_fin, r_err, r_all;
    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_turn, r_wait;

    assign load_ok  = (loaded_reg < NO_RUNNER) && (in_bur_reg != '0);
    assign found    = (best_reg != NO_RUNNER);
    assign done_now = (best_rem_reg == BUR_W'(1));
    assign time_inc = (time_reg == {TIME_W{1'b1}}) ? time_reg : time_reg + 1'b1;
    assign sum_ext  = {{(TIME_W-BUR_W-1){1'b0}}, best_sum_reg};
    assign turn     = time_inc - {{(TIME_W-ARR_W){1'b0}}, best_arr_reg};
    assign wait_t   = (time_inc >= sum_ext) ? time_inc - sum_ext : '0;

    always_comb begin
        loaded_next   = loaded_reg;
        finished_next = finished_reg;
        time_next     = time_reg;
        prev_next     = prev_reg;
        r_ran  = 1'b0;
        r_sw   = 1'b0;
        r_fin  = 1'b0;
        r_err  = 1'b0;
        r_id   = '0;
        r_turn = '0;
        r_wait = '0;
        if (kind_reg == pps_pkg::KIND_LOAD) begin
            if (load_ok) begin
                loaded_next = loaded_reg + 1'b1;
                r_id        = to_id(loaded_reg);
            end else begin
                r_err = 1'b1;
            end
        end else begin
            time_next = time_inc;
            if (found) begin
                r_ran     = 1'b1;
                r_id      = to_id(best_reg);
                r_sw      = (prev_reg != best_reg);
                prev_next = best_reg;
                if (done_now) begin
                    r_fin         = 1'b1;
                    r_turn        = turn;
                    r_wait        = wait_t;
                    finished_next = finished_reg + 1'b1;
                end
            end
        end
        r_all = (finished_next == loaded_next);
        m_tdata_next = {7'b0, r_err, r_all, r_wait, r_turn, r_fin, r_sw, r_id, r_ran};
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && kind_reg == pps_pkg::KIND_LOAD && load_ok) begin
            arrival_reg[loaded_reg[IDX_W-1:0]]   <= in_arr_reg;
            burst_reg[loaded_reg[IDX_W-1:0]]     <= in_bur_reg;
            priority_reg[loaded_reg[IDX_W-1:0]]  <= in_pri_reg;
            remaining_reg[loaded_reg[IDX_W-1:0]] <= in_bur_reg;
        end else if (cmd.commit && kind_reg == pps_pkg::KIND_TICK && found) begin
            remaining_reg[best_reg[IDX_W-1:0]]   <= best_rem_reg - 1'b1;
        end
        if (cmd.commit) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg   <= '0;
            finished_reg <= '0;
            time_reg     <= '0;
            prev_reg     <= NO_RUNNER;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.commit) begin
                loaded_reg   <= loaded_next;
                finished_reg <= finished_next;
                time_reg     <= time_next;
                prev_reg     <= prev_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign status.out_busy = m_tvalid_reg && !m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;

endmodule

// File: sv/preemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// tick-driven preemptive priority scheduler over a table of tasks
// ----------------------------------------------------------------------------
// a load transaction is captured and then committed. a tick transaction is
// captured, then the slot scan reads one table entry per cycle to track the
// eligible task with the lowest priority number, and a commit step then
// updates the tables and writes the result register.
// a new transaction is taken while the previous result waits in the output
// register; commit stalls only if that register is still occupied.
module preemptive_priority_scheduler (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] arrival_time, [31:16] burst_length, [39:32] task_priority
    input  logic [pps_pkg::IN_DATA_W-1:0]  s_tdata,
    // [0] kind
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] ran, [4:1] task_id, [5] switched, [6] finished, [30:7] turnaround,
    // [54:31] waiting, [55] all_done, [56] error, [63:57] zero
    output logic [pps_pkg::OUT_DATA_W-1:0] m_tdata
);

    pps_pkg::pps_cmd_t    cmd;
    pps_pkg::pps_status_t status;

    pps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pps_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: sv/pps_checker.sv
// ----------------------------------------------------------------------------
// pps_checker
// port-level checks of the scheduler result stream
// ----------------------------------------------------------------------------
module pps_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [pps_pkg::OUT_DATA_W-1:0] m_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // completion only on a served tick
    a_fin_ran: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[6] |-> m_tdata[0])
        else $error("finished without ran");

    // refused load reports nothing served
    a_err_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[56] |-> !m_tdata[0] && m_tdata[4:1] == '0)
        else $error("error with service fields set");

    // waiting never exceeds turnaround
    a_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[54:31] <= m_tdata[30:7])
        else $error("waiting above turnaround");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/sv/tb_preemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// tb_preemptive_priority_scheduler
// self-checking stream testbench for the preemptive priority scheduler
// ----------------------------------------------------------------------------
// a short table of directed load and tick transactions comes first: the empty
// table, a refused zero-burst load, priority ties, a preempting arrival and a
// load made after time has moved on. random transactions follow, mostly ticks
// over tasks with random arrival, burst and priority, until the table fills
// and further loads are refused. every result is compared field by field with
// a scheduler model kept in the testbench, or with the expected fields typed
// into a directed row, under bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module tb_preemptive_priority_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_TASKS  = pps_pkg::MAX_TASKS;
    localparam int TIME_W     = pps_pkg::TIME_W;
    localparam int ARR_W      = pps_pkg::ARR_W;
    localparam int BUR_W      = pps_pkg::BUR_W;
    localparam int PRI_W      = pps_pkg::PRI_W;
    localparam int IN_DATA_W  = pps_pkg::IN_DATA_W;
    localparam int OUT_DATA_W = pps_pkg::OUT_DATA_W;

    localparam int N_RANDOM   = 1180;
    localparam int IDLE_LIMIT = 2000;
    localparam int N_DIRECTED = 20;

    typedef struct packed {
        logic [6:0]  pad;
        logic        error;
        logic        all_done;
        logic [23:0] waiting;
        logic [23:0] turnaround;
        logic        finished;
        logic        switched;
        logic [3:0]  task_id;
        logic        ran;
    } sched_result_t;

    typedef struct {
        logic        kind;
        logic [15:0] arr;
        logic [15:0] bur;
        logic [7:0]  pri;
        bit          typed;
        logic [3:0]  want_id;
        logic        want_done;
        logic        want_err;
    } stim_row_t;

    typedef struct {
        bit            typed;
        sched_result_t res;
    } stim_note_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = pps_pkg::KIND_TICK;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // model state
    logic [ARR_W-1:0]  task_arrival [MAX_TASKS];
    logic [BUR_W-1:0]  task_burst   [MAX_TASKS];
    logic [BUR_W-1:0]  task_left    [MAX_TASKS];
    logic [PRI_W-1:0]  task_prio    [MAX_TASKS];
    int                n_loaded    = 0;
    int                n_finished  = 0;
    logic [TIME_W-1:0] sched_time  = '0;
    int                last_served = MAX_TASKS;

    sched_result_t expected_q [$];
    stim_note_t    note_q     [$];

    int errors      = 0;
    int idle_cycles = 0;
    int burst_left  = 0;
    int n_accepted  = 0;
    int n_refused   = 0;
    int n_served    = 0;
    int n_completed = 0;
    int n_idle      = 0;
    int n_switches  = 0;

    stim_row_t dir_tab [N_DIRECTED] = '{
        '{pps_pkg::KIND_TICK, 16'h0000, 16'h0000, 8'h00, 1'b1, 4'd0, 1'b1, 1'b0},
        '{pps_pkg::KIND_LOAD, 16'hffff, 16'h0000, 8'hff, 1'b1, 4'd0, 1'b1, 1'b1},
        '{pps_pkg::KIND_LOAD, 16'h0000, 16'h0001, 8'h00, 1'b1, 4'd0, 1'b0, 1'b0},
        '{pps_pkg::KIND_LOAD, 16'h0004, 16'h0003, 8'h09, 1'b1, 4'd1, 1'b0, 1'b0},
        '{pps_pkg::KIND_LOAD, 16'h0000, 16'h0002, 8'h09, 1'b1, 4'd2, 1'b0, 1'b0},
        '{pps_pkg::KIND_LOAD, 16'h0001, 16'h0002, 8'h09, 1'b0, 4'd0, 1'b0, 1'b0},
        '{pps_pkg::KIND_LOAD, 16'h0008, 16'h0001, 8'h01, 1'b0, 4'd0, 1'b0, 1'b0},
        '{pps_pkg::KIND_TICK, 16'h0000, 16'h0000, 8'h00, 1'b0, 4'd0, 1'b0, 1'b0},
        '{pps_pkg::KIND_TICK, 16'hffff, 16'hffff, 8'hff, 1'b0, 4'd0, 1'b0, 1'b0},
        '{pps_pkg::KIND_TICK, 16'h0000, 16'h0000, 8'h00, 1'b0, 4'd0, 1'b0, 1'b0},
        '{pps_pkg::KIND_TICK, 16'h0000, 16'h0000, 8'h00, 1'b0, 4'd0, 1'b0, 1'b0},
        '{pps_pkg::KIND_TICK, 16'h0000, 16'h0000, 8'h00, 1'b0, 4'd0, 1'b0, 1'b0},
        '{pps_pkg::KIND_TICK, 16'h0000, 16'h0000, 8'h00, 1'b0, 4'd0, 1'b0, 1'b0},
        '{pps_pkg::KIND_TICK, 16'h0000, 16'h0000, 8'h00, 1'b0, 4'd0, 1'b0, 1'b0},
        '{pps_pkg::KIND_TICK, 16'h0000, 16'h0000, 8'h00, 1'b0, 4'd0, 1'b0, 1'b0},
        '{pps_pkg::KIND_TICK, 16'h0000, 16'h0000, 8'h00, 1'b0, 4'd0, 1'b0, 1'b0},
        '{pps_pkg::KIND_TICK, 16'h0000, 16'h0000, 8'h00, 1'b0, 4'd0, 1'b0, 1'b0},
        '{pps_pkg::KIND_LOAD, 16'h0000, 16'h0001, 8'hff, 1'b0, 4'd0, 1'b0, 1'b0},
        '{pps_pkg::KIND_TICK, 16'h0000, 16'h0000, 8'h00, 1'b0, 4'd0, 1'b0, 1'b0},
        '{pps_pkg::KIND_TICK, 16'h0000, 16'h0000, 8'h00, 1'b0, 4'd0, 1'b0, 1'b0}
    };

    preemptive_priority_scheduler DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    function automatic sched_result_t schedule_step(input logic kind,
                                                    input logic [ARR_W-1:0] arr,
                                                    input logic [BUR_W-1:0] bur,
                                                    input logic [PRI_W-1:0] pri);
        sched_result_t     res;
        int                pick;
        int                best;
        logic [TIME_W-1:0] ta;
        res  = '0;
        pick = MAX_TASKS;
        best = 256;
        if (kind == pps_pkg::KIND_LOAD) begin
            if (n_loaded >= MAX_TASKS || bur == '0) begin
                res.error = 1'b1;
            end else begin
                task_arrival[n_loaded] = arr;
                task_burst[n_loaded]   = bur;
                task_left[n_loaded]    = bur;
                task_prio[n_loaded]    = pri;
                res.task_id            = n_loaded[3:0];
                n_loaded++;
            end
        end else begin
            for (int i = 0; i < n_loaded; i++) begin
                if (TIME_W'(task_arrival[i]) <= sched_time && task_left[i] != '0 &&
                    int'(task_prio[i]) < best) begin
                    best = int'(task_prio[i]);
                    pick = i;
                end
            end
            if (sched_time != '1)
                sched_time++;
            if (pick < MAX_TASKS) begin
                res.ran      = 1'b1;
                res.task_id  = pick[3:0];
                res.switched = (last_served != pick);
                last_served  = pick;
                task_left[pick]--;
                if (task_left[pick] == '0) begin
                    ta             = sched_time - TIME_W'(task_arrival[pick]);
                    res.finished   = 1'b1;
                    res.turnaround = ta;
                    res.waiting    = (ta >= TIME_W'(task_burst[pick])) ?
                                     ta - TIME_W'(task_burst[pick]) : '0;
                    n_finished++;
                end
            end
        end
        res.all_done = (n_finished == n_loaded);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t ns %s: expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // input and output transaction monitor
    always @(posedge aclk) begin
        sched_result_t pred;
        sched_result_t want;
        sched_result_t got;
        stim_note_t    note;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                note = note_q.pop_front();
                pred = schedule_step(s_tuser, s_tdata[15:0], s_tdata[31:16],
                                     s_tdata[39:32]);
                expected_q.push_back(note.typed ? note.res : pred);
                if (pred.error) n_refused++;
                else if (s_tuser == pps_pkg::KIND_LOAD) n_accepted++;
                else if (!pred.ran) n_idle++;
                if (pred.ran) n_served++;
                if (pred.finished) n_completed++;
                if (pred.switched) n_switches++;
            end
            if (m_tvalid && m_tready) begin
                got = sched_result_t'(m_tdata);
                if (expected_q.size() == 0) begin
                    errors++;
                    $display("%0t ns unexpected result: expected none actual %h",
                             $time, m_tdata);
                end else begin
                    want = expected_q.pop_front();
                    check_field("ran", 24'(want.ran), 24'(got.ran));
                    check_field("task_id", 24'(want.task_id), 24'(got.task_id));
                    check_field("switched", 24'(want.switched), 24'(got.switched));
                    check_field("finished", 24'(want.finished), 24'(got.finished));
                    check_field("turnaround", want.turnaround, got.turnaround);
                    check_field("waiting", want.waiting, got.waiting);
                    check_field("all_done", 24'(want.all_done), 24'(got.all_done));
                    check_field("error", 24'(want.error), 24'(got.error));
                    check_field("pad", 24'(want.pad), 24'(got.pad));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("preemptive_priority_scheduler: mismatch");
            $finish;
        end
    end

    // receiver stall pattern
    always @(negedge aclk) begin
        int rx_cycle;
        int rx_mode;
        rx_cycle++;
        if (rx_cycle % 128 == 0)
            rx_mode = $urandom_range(0, 2);
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 9) < 7);
            default: m_tready <= ((rx_cycle % 8) < 3);
        endcase
    end

    task automatic send_item(input logic kind, input logic [IN_DATA_W-1:0] data,
                             input bit typed, input sched_result_t res);
        stim_note_t note;
        note.typed = typed;
        note.res   = res;
        note_q.push_back(note);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic sender_gap(input bit drain);
        int gap;
        if (!drain && burst_left > 0) begin
            burst_left--;
            return;
        end
        s_tvalid <= 1'b0;
        gap = $urandom_range(1, 12);
        repeat (gap) @(negedge aclk);
        while (drain && expected_q.size() != 0) @(negedge aclk);
        burst_left = $urandom_range(0, 24);
    endtask

    initial begin
        sched_result_t        typed_res;
        logic [IN_DATA_W-1:0] data;
        logic [15:0]          arr;
        logic [15:0]          bur;
        logic [7:0]           pri;
        int                   roll;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_tab[k]) begin
            typed_res          = '0;
            typed_res.task_id  = dir_tab[k].want_id;
            typed_res.all_done = dir_tab[k].want_done;
            typed_res.error    = dir_tab[k].want_err;
            send_item(dir_tab[k].kind, {dir_tab[k].pri, dir_tab[k].bur, dir_tab[k].arr},
                      dir_tab[k].typed, typed_res);
            sender_gap(1'b0);
        end
        sender_gap(1'b1);

        for (int n = 0; n < N_RANDOM; n++) begin
            roll = $urandom_range(0, 99);
            data = IN_DATA_W'({$urandom, $urandom});
            if (roll < 6 && n_loaded < MAX_TASKS) begin
                arr  = sched_time[15:0] + 16'($urandom_range(0, 200));
                bur  = 16'($urandom_range(1, 120));
                pri  = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) :
                                              8'($urandom_range(0, 255));
                send_item(pps_pkg::KIND_LOAD, {pri, bur, arr}, 1'b0, '0);
            end else if (roll < 8) begin
                data[31:16] = '0;
                send_item(pps_pkg::KIND_LOAD, data, 1'b0, '0);
            end else if (roll < 16 && n_loaded >= MAX_TASKS) begin
                send_item(pps_pkg::KIND_LOAD, data, 1'b0, '0);
            end else begin
                send_item(pps_pkg::KIND_TICK, data, 1'b0, '0);
            end
            sender_gap($urandom_range(0, 199) == 0);
        end

        sender_gap(1'b1);
        repeat (40) @(posedge aclk);
        $display("covered %0d loads, %0d refused loads, %0d served ticks, %0d idle ticks",
                 n_accepted, n_refused, n_served, n_idle);
        $display("with %0d task completions and %0d task switches", n_completed, n_switches);
        if (errors == 0)
            $display("preemptive_priority_scheduler: match");
        else
            $display("preemptive_priority_scheduler: mismatch");
        $finish;
    end

endmodule

// File: sim.f
sv/pps_pkg.sv
sv/pps_ctrl.sv
sv/pps_datapath.sv
sv/preemptive_priority_scheduler.sv
sv/pps_checker.sv
tb/sv/tb_preemptive_priority_scheduler.sv
